>>> design/cesc_pkg.sv
// ----------------------------------------------------------------------------
// cesc_pkg: shared types and constants of the C escape unescaper
// Result kinds, character codes and the record passed from the front end
// through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package cesc_pkg;

  // Result kinds carried on the output tuser.
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_ERASE = 2'd1;
  localparam logic [1:0] KIND_END   = 2'd2;

  localparam int OUT_LEN_W = 16;

  // Depth of the queue between the front end and the back end.
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // Character codes.
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_BS   = 8'h08;
  localparam logic [7:0] CH_BSL  = 8'h5C;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_7    = 8'h37;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_N    = 8'h6E;
  localparam logic [7:0] CH_R    = 8'h72;
  localparam logic [7:0] CH_B    = 8'h62;
  localparam logic [7:0] CH_T    = 8'h74;
  localparam logic [7:0] CH_F    = 8'h66;
  localparam logic [7:0] CH_V    = 8'h76;
  localparam logic [7:0] CH_X    = 8'h78;

  // Work for one input item: an optional flushed escape byte, then an
  // optional main result.
  typedef struct packed {
    logic                 flush;
    logic [7:0]           flush_byte;
    logic                 main_valid;
    logic [1:0]           main_kind;
    logic [7:0]           main_byte;
    logic [OUT_LEN_W-1:0] main_len;
  } cesc_rec_t;

endpackage

`default_nettype wire

>>> design/c_escape_unescaper.sv
// ----------------------------------------------------------------------------
// c_escape_unescaper: streaming C escape sequence decoder
// Source bytes in, decoded bytes, erase marks and end-of-string marks out.
// ----------------------------------------------------------------------------
// Usage:
// - Input stream: one source byte per item in s_tdata; s_tuser set marks the
//   first byte of a new string and clears the decode state first.
// - Output stream: m_tuser gives the kind (data, erase, end), m_tdata holds
//   the byte and the output length, m_tlast marks the final result of an item.
// - cfg_we/cfg_wdata write the length limit max_len; write it only while
//   the block is idle.
// - Path: the record of an item enters the queue at the edge that accepts
//   the item, and its first result goes from there into the output register.
// - Throughput: one item per cycle while s_tready is high. An item that ends
//   a numeric escape on a byte outside its digits can give two results,
//   sent in turn. The output register is fed from a four-entry record queue.
// - Items causing no result (backslash, escape digits but the last, bytes
//   after the end) push no record and reach no output.
// - Reset clears the decode state, the queue and the output stage, and sets
//   max_len to 65535.
// - When the receiver stalls, the output holds its result, the queue fills,
//   and s_tready drops once four records wait.
// ----------------------------------------------------------------------------
`default_nettype none

module c_escape_unescaper
  import cesc_pkg::*;
#(
  parameter int LEN_WIDTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] in_byte
  input  wire logic        s_tuser,   // [0] start_flag
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] out_byte, [23:8] out_length
  output logic [1:0]       m_tuser,   // [1:0] out_kind
  output logic             m_tlast
);

  logic      accept;
  logic      push;
  logic      pop;
  logic      q_valid;
  cesc_rec_t front_rec;
  cesc_rec_t q_rec;

  assign accept = s_tvalid && s_tready;

  cesc_front #(
    .LEN_WIDTH(LEN_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .accept   (accept),
    .in_byte  (s_tdata),
    .in_start (s_tuser),
    .push     (push),
    .rec      (front_rec)
  );

  cesc_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_rec(front_rec),
    .not_full(s_tready),
    .pop     (pop),
    .q_valid (q_valid),
    .q_rec   (q_rec)
  );

  cesc_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_rec   (q_rec),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

endmodule

`default_nettype wire

>>> design/cesc_front.sv
// ----------------------------------------------------------------------------
// cesc_front: escape decoder front end
// Holds the decode state and the length limit, classifies each accepted byte
// and pushes one record describing its results, if any, into the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module cesc_front
  import cesc_pkg::*;
#(
  parameter int LEN_WIDTH = 16
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_we,
  input  wire logic [15:0]     cfg_wdata,
  input  wire logic            accept,
  input  wire logic [7:0]      in_byte,
  input  wire logic            in_start,
  output logic                 push,
  output cesc_rec_t            rec
);

  localparam int CW = (LEN_WIDTH > OUT_LEN_W) ? LEN_WIDTH : OUT_LEN_W;
  localparam logic [LEN_WIDTH-1:0] LEN_MAX = {LEN_WIDTH{1'b1}};

  typedef enum logic [2:0] {
    M_PLAIN, M_ESC, M_OCT1, M_OCT2, M_HEX0, M_HEX1
  } mode_t;

  mode_t                mode, mode_next;
  logic [8:0]           ev, ev_next;
  logic [LEN_WIDTH-1:0] pos, pos_next;
  logic [LEN_WIDTH-1:0] cnt, cnt_next;
  logic                 done, done_next;
  logic [15:0]          max_len;

  mode_t                e_mode;
  logic [8:0]           e_ev;
  logic [LEN_WIDTH-1:0] e_pos, e_cnt, cnt1;
  logic                 e_done;
  logic                 plain;
  logic [4:0]           hx;
  logic [CW-1:0]        pos_ext, lim_ml, lim_max, lim, cnt_ext;
  cesc_rec_t            r;

  function automatic logic [LEN_WIDTH-1:0] sat_inc(input logic [LEN_WIDTH-1:0] v);
    sat_inc = (v == LEN_MAX) ? v : v + 1'b1;
  endfunction

  // Bit 4 flags a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    hex_digit = 5'd0;
    if (c >= CH_0 && c <= CH_9) begin
      d = c - CH_0;
      hex_digit = {1'b1, d[3:0]};
    end else if (c >= CH_LA && c <= CH_LF) begin
      d = c - CH_LA + 8'd10;
      hex_digit = {1'b1, d[3:0]};
    end else if (c >= CH_UA && c <= CH_UF) begin
      d = c - CH_UA + 8'd10;
      hex_digit = {1'b1, d[3:0]};
    end
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    is_oct = (c >= CH_0) && (c <= CH_7);
  endfunction

  always_comb begin
    // A start byte sees cleared state.
    e_mode = in_start ? M_PLAIN : mode;
    e_ev   = in_start ? 9'd0 : ev;
    e_pos  = in_start ? '0 : pos;
    e_cnt  = in_start ? '0 : cnt;
    e_done = in_start ? 1'b0 : done;

    mode_next = e_mode;
    ev_next   = e_ev;
    pos_next  = e_pos;
    cnt_next  = e_cnt;
    done_next = e_done;
    plain     = 1'b0;
    r         = '0;
    hx        = hex_digit(in_byte);
    cnt1      = e_cnt;
    cnt_ext   = '0;

    pos_ext = CW'(sat_inc(e_pos));
    lim_ml  = CW'(max_len);
    lim_max = CW'(LEN_MAX);
    lim     = (lim_ml < lim_max) ? lim_ml : lim_max;

    if (!e_done) begin
      pos_next = sat_inc(e_pos);
      unique case (e_mode)
        M_ESC: begin
          mode_next    = M_PLAIN;
          r.main_valid = 1'b1;
          r.main_kind  = KIND_DATA;
          case (in_byte)
            CH_NUL: r.main_kind = KIND_END;
            CH_N:   r.main_byte = 8'd10;
            CH_R:   r.main_byte = 8'd13;
            CH_B:   r.main_byte = 8'd8;
            CH_T:   r.main_byte = 8'd9;
            CH_F:   r.main_byte = 8'd12;
            CH_V:   r.main_byte = 8'd11;
            CH_X: begin
              r.main_valid = 1'b0;
              mode_next    = M_HEX0;
            end
            default: begin
              if (is_oct(in_byte)) begin
                r.main_valid = 1'b0;
                ev_next      = {6'd0, in_byte[2:0]};
                mode_next    = M_OCT1;
              end else begin
                r.main_byte = in_byte;
              end
            end
          endcase
        end
        M_OCT1, M_OCT2: begin
          if (is_oct(in_byte)) begin
            ev_next = {e_ev[5:0], in_byte[2:0]};
            if (e_mode == M_OCT1) begin
              mode_next = M_OCT2;
            end else begin
              mode_next    = M_PLAIN;
              r.main_valid = 1'b1;
              r.main_kind  = KIND_DATA;
              r.main_byte  = {e_ev[4:0], in_byte[2:0]};
            end
          end else begin
            r.flush      = 1'b1;
            r.flush_byte = e_ev[7:0];
            plain        = 1'b1;
          end
        end
        M_HEX0: begin
          if (hx[4]) begin
            ev_next   = {5'd0, hx[3:0]};
            mode_next = M_HEX1;
          end else begin
            r.flush      = 1'b1;
            r.flush_byte = CH_X;
            plain        = 1'b1;
          end
        end
        M_HEX1: begin
          if (hx[4]) begin
            mode_next    = M_PLAIN;
            r.main_valid = 1'b1;
            r.main_kind  = KIND_DATA;
            r.main_byte  = {e_ev[3:0], hx[3:0]};
          end else begin
            r.flush      = 1'b1;
            r.flush_byte = e_ev[7:0];
            plain        = 1'b1;
          end
        end
        default: plain = 1'b1;
      endcase

      // The flushed escape byte counts before the reprocessed byte is seen.
      cnt1 = r.flush ? sat_inc(e_cnt) : e_cnt;

      if (plain) begin
        mode_next = M_PLAIN;
        if (in_byte == CH_NUL || pos_ext > lim) begin
          r.main_valid = 1'b1;
          r.main_kind  = KIND_END;
        end else if (in_byte == CH_BSL) begin
          mode_next = M_ESC;
        end else if (in_byte == CH_BS) begin
          if (cnt1 != '0) begin
            r.main_valid = 1'b1;
            r.main_kind  = KIND_ERASE;
          end
        end else begin
          r.main_valid = 1'b1;
          r.main_kind  = KIND_DATA;
          r.main_byte  = in_byte;
        end
      end

      cnt_next = cnt1;
      if (r.main_valid) begin
        case (r.main_kind)
          KIND_DATA:  cnt_next = sat_inc(cnt1);
          KIND_ERASE: cnt_next = cnt1 - 1'b1;
          default: begin
            cnt_ext    = CW'(cnt1);
            r.main_len = cnt_ext[OUT_LEN_W-1:0];
            done_next  = 1'b1;
            mode_next  = M_PLAIN;
          end
        endcase
      end
    end
  end

  assign push = accept && (r.flush || r.main_valid);
  assign rec  = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= M_PLAIN;
      ev      <= 9'd0;
      pos     <= '0;
      cnt     <= '0;
      done    <= 1'b0;
      max_len <= 16'hFFFF;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (accept) begin
        mode <= mode_next;
        ev   <= ev_next;
        pos  <= pos_next;
        cnt  <= cnt_next;
        done <= done_next;
      end
    end
  end

  a_done_plain : assert property (@(posedge clk) disable iff (rst)
    done |-> (mode == M_PLAIN))
    else $error("ended string left an escape mode open");

  a_done_silent : assert property (@(posedge clk) disable iff (rst)
    (accept && done && !in_start) |-> !push)
    else $error("result produced after end of string");

  a_done_pos_hold : assert property (@(posedge clk) disable iff (rst)
    (accept && done && !in_start) |=> $stable(pos))
    else $error("position advanced after end of string");

  a_flush_only_escape : assert property (@(posedge clk) disable iff (rst)
    (push && rec.flush) |-> (in_start == 1'b0) && (mode != M_PLAIN) && (mode != M_ESC))
    else $error("flush outside a numeric escape");

endmodule

`default_nettype wire

>>> design/cesc_fifo.sv
// ----------------------------------------------------------------------------
// cesc_fifo: record queue
// Short register queue between the front end and the back end so that each
// side can stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module cesc_fifo
  import cesc_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  cesc_rec_t       push_rec,
  output logic            not_full,
  input  wire logic       pop,
  output logic            q_valid,
  output cesc_rec_t       q_rec
);

  cesc_rec_t           slots [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign not_full = (count != QCNT_W'(QDEPTH));
  assign q_valid  = (count != '0);
  assign q_rec    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    push |-> (not_full || pop))
    else $error("push into a full queue");

  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    pop |-> q_valid)
    else $error("pop from an empty queue");

  a_count_range : assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

`default_nettype wire

>>> design/cesc_back.sv
// ----------------------------------------------------------------------------
// cesc_back: result sequencer
// Unpacks each queued record into one or two results and drives them through
// a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module cesc_back
  import cesc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  cesc_rec_t        q_rec,
  output logic             pop,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  // Set while the flushed byte of the head record has been sent and its main
  // result is still to go.
  logic        phase;
  logic        load;
  logic        send_flush;
  logic [1:0]  cur_kind;
  logic [7:0]  cur_byte;
  logic [15:0] cur_len;
  logic        cur_last;

  assign load       = q_valid && (!m_tvalid || m_tready);
  assign send_flush = q_rec.flush && !phase;
  assign pop        = load && !(send_flush && q_rec.main_valid);

  always_comb begin
    if (send_flush) begin
      cur_kind = KIND_DATA;
      cur_byte = q_rec.flush_byte;
      cur_len  = '0;
      cur_last = !q_rec.main_valid;
    end else begin
      cur_kind = q_rec.main_kind;
      cur_byte = (q_rec.main_kind == KIND_DATA) ? q_rec.main_byte : 8'd0;
      cur_len  = (q_rec.main_kind == KIND_END) ? q_rec.main_len : 16'd0;
      cur_last = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      phase    <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        phase    <= !pop;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {cur_len, cur_byte};
      m_tuser <= cur_kind;
      m_tlast <= cur_last;
    end
  end

  a_phase_holds_head : assert property (@(posedge clk) disable iff (rst)
    phase |-> (q_valid && q_rec.flush && q_rec.main_valid))
    else $error("second result pending without its record");

  a_phase_after_send : assert property (@(posedge clk) disable iff (rst)
    phase |-> m_tvalid)
    else $error("second result pending but nothing sent");

  a_split_not_last : assert property (@(posedge clk) disable iff (rst)
    (load && !pop) |=> (m_tvalid && !m_tlast))
    else $error("first of two results marked last");

endmodule

`default_nettype wire
